>>> rtl/hnic_pkg.sv
// ----------------------------------------------------------------------------
// hnic_pkg: shared types and constants for the hashed name index cache
// Holds the FNV-1a constants, table geometry, the job record that travels
// from the front part to the back part, and the result record.
// ----------------------------------------------------------------------------
package hnic_pkg;

  localparam int BYTE_W        = 8;
  localparam int HASH_W        = 32;
  localparam int IDX_W         = 16;
  localparam int INDEX_BITS    = 16;
  localparam int CNT_W         = 64;

  // Table depth must be a power of two: the slot is the low hash bits.
  localparam int TABLE_ENTRIES = 256;
  localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);

  // Job queue depth must be a power of two so the pointers wrap freely.
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int S_TDATA_W     = 24;
  localparam int M_TDATA_W     = 152;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811c_9dc5;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_STORE  = 1'b1
  } action_t;

  typedef struct packed {
    logic [HASH_W-1:0]     hash;
    action_t               action;
    logic [INDEX_BITS-1:0] index;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_push_t;

  typedef enum logic {
    S_IDLE,
    S_CMP
  } back_state_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] lookups_seen;
    logic [CNT_W-1:0] hits_seen;
  } result_t;

endpackage

>>> rtl/hnic_front.sv
// ----------------------------------------------------------------------------
// hnic_front: name byte intake and FNV-1a hashing
// Folds one byte per cycle into the running hash while the job queue has room
// and hands a finished name to the job queue on its last byte.
// ----------------------------------------------------------------------------
module hnic_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_valid,
  output logic                           s_ready,
  input  logic                           action,
  input  logic [hnic_pkg::BYTE_W-1:0]    name_byte,
  input  logic                           last_byte,
  input  logic [hnic_pkg::IDX_W-1:0]     store_index,
  input  logic                           q_full,
  output hnic_pkg::q_push_t              push
);
  import hnic_pkg::*;

  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] running_hash_next;
  logic [HASH_W-1:0] mixed;
  logic [HASH_W-1:0] hash_step;
  logic              accept;

  assign s_ready   = !q_full;
  assign accept    = s_valid && s_ready;
  assign mixed     = running_hash ^ {{(HASH_W-BYTE_W){1'b0}}, name_byte};
  // Product is kept modulo 2^32.
  assign hash_step = mixed * FNV_PRIME;

  always_comb begin
    running_hash_next = running_hash;
    if (accept) begin
      running_hash_next = last_byte ? FNV_BASIS : hash_step;
    end
    push.valid      = accept && last_byte;
    push.job.hash   = hash_step;
    push.job.action = action_t'(action);
    push.job.index  = store_index[INDEX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
    end else begin
      running_hash <= running_hash_next;
    end
  end

endmodule

>>> rtl/hnic_queue.sv
// ----------------------------------------------------------------------------
// hnic_queue: short job queue between the front and back parts
// A small FIFO of finished names, so hashing and table work stall apart.
// ----------------------------------------------------------------------------
module hnic_queue (
  input  logic              clk,
  input  logic              rst,
  input  hnic_pkg::q_push_t push,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output hnic_pkg::job_t    head
);
  import hnic_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/hnic_back.sv
// ----------------------------------------------------------------------------
// hnic_back: slot table, hit check, counters and result register
// Takes one job at a time: a store writes its slot, a lookup
// reads the slot, then compares and loads the result register.
// ----------------------------------------------------------------------------
module hnic_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  hnic_pkg::job_t   q_head,
  output logic             q_pop,
  output logic             m_valid,
  input  logic             m_ready,
  output hnic_pkg::result_t m_res
);
  import hnic_pkg::*;

  typedef struct packed {
    logic [HASH_W-1:0]     tag;
    logic [INDEX_BITS-1:0] index;
  } slot_entry_t;

  slot_entry_t              slot_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] slot_valid;

  slot_entry_t       rd_entry;
  logic              rd_valid;
  logic [HASH_W-1:0] cur_hash;

  back_state_t       state;
  back_state_t       state_next;

  logic [CNT_W-1:0]  lookup_cnt;
  logic [CNT_W-1:0]  hit_cnt;
  logic [CNT_W-1:0]  lookup_cnt_next;
  logic [CNT_W-1:0]  hit_cnt_next;

  logic [SLOT_BITS-1:0] head_slot;
  logic              rd_en;
  logic              wr_en;
  logic              out_load;
  logic              cmp_hit;

  assign head_slot = q_head.hash[SLOT_BITS-1:0];
  assign cmp_hit   = rd_valid && (rd_entry.tag == cur_hash);
  assign lookup_cnt_next = lookup_cnt + 1'b1;
  assign hit_cnt_next    = cmp_hit ? hit_cnt + 1'b1 : hit_cnt;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.action == ACT_STORE) begin
            wr_en = 1'b1;
          end else begin
            rd_en      = 1'b1;
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (!m_valid || m_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Table array and read register. Writes and reads never share a cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[head_slot] <= '{tag: q_head.hash, index: q_head.index};
    end
    if (rd_en) begin
      rd_entry <= slot_mem[head_slot];
      rd_valid <= slot_valid[head_slot];
      cur_hash <= q_head.hash;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_res.found        <= cmp_hit;
      m_res.found_index  <= cmp_hit ? IDX_W'(rd_entry.index) : '0;
      m_res.lookups_seen <= lookup_cnt_next;
      m_res.hits_seen    <= hit_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      lookup_cnt <= '0;
      hit_cnt    <= '0;
      m_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        slot_valid[head_slot] <= 1'b1;
      end
      if (out_load) begin
        lookup_cnt <= lookup_cnt_next;
        hit_cnt    <= hit_cnt_next;
        m_valid    <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  a_lookup_issue: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !q_empty && q_head.action == ACT_LOOKUP)
      |=> (state == S_CMP && cur_hash == $past(q_head.hash)))
    else $error("lookup did not enter compare with its hash");

  a_store_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !q_empty && q_head.action == ACT_STORE)
      |=> (slot_valid[$past(head_slot)] && state == S_IDLE))
    else $error("store did not mark its slot valid");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_valid && m_res.lookups_seen == $past(lookup_cnt) + 1'b1))
    else $error("result loaded without a lookup count step");

  a_miss_result: assert property (@(posedge clk) disable iff (rst)
    (out_load && !cmp_hit)
      |=> (!m_res.found && m_res.found_index == '0
           && m_res.hits_seen == $past(hit_cnt)))
    else $error("miss result carries hit data");

endmodule

>>> rtl/hashed_name_index_cache.sv
// ----------------------------------------------------------------------------
// hashed_name_index_cache: direct-mapped name to index cache
// Names arrive one byte per request on the slave stream and are hashed with
// 32-bit FNV-1a. On the last byte, the name is either looked up or stored
// in a 256-slot direct-mapped table keyed by the low hash bits.
//
// Slave channel: one name byte per request. tlast marks the last byte of a
// name, tuser carries the action (0 lookup, 1 store), which only matters on
// the last byte, as does the index in tdata.
// Master channel: one result request per lookup, none for stores or for
// bytes that are not last. A hit needs a valid slot whose stored tag equals
// the full 32-bit hash.
// Throughput: the front takes one byte per cycle. The back handles one name
// at a time: a store writes its slot, a lookup reads the table slot, then
// compares. A two-entry job queue sits between them, and s_tready drops
// only while that queue is full.
// A lookup result passes the job queue, the table read register and the
// result register, and waits in the queue while the back part is busy.
// Reset clears the running hash, all slot valid marks, both counters, the
// job queue and the result valid flag at once; no clearing pass is needed.
// While the receiver stalls, the result holds, one more lookup may sit in
// compare, and the queue then fills and stalls the slave side.
// ----------------------------------------------------------------------------
module hashed_name_index_cache (
  input  logic                               clk,
  input  logic                               rst,
  // Slave stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // tdata fields from bit 0: name_byte[7:0], store_index[23:8].
  input  logic [hnic_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic                               s_tlast,
  // tuser fields from bit 0: action[0].
  input  logic                               s_tuser,
  // Master stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tdata fields from bit 0: found[0], found_index[16:1],
  // lookups_seen[80:17], hits_seen[144:81], zero fill[151:145].
  output logic [hnic_pkg::M_TDATA_W-1:0]     m_tdata
);
  import hnic_pkg::*;

  q_push_t push;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  job_t    q_head;
  result_t res;

  hnic_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_tvalid),
    .s_ready     (s_tready),
    .action      (s_tuser),
    .name_byte   (s_tdata[BYTE_W-1:0]),
    .last_byte   (s_tlast),
    .store_index (s_tdata[BYTE_W+IDX_W-1:BYTE_W]),
    .q_full      (q_full),
    .push        (push)
  );

  hnic_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  hnic_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (res)
  );

  // Pack the result with the first field in the low bits.
  assign m_tdata = {{(M_TDATA_W-1-IDX_W-2*CNT_W){1'b0}},
                    res.hits_seen, res.lookups_seen, res.found_index, res.found};

endmodule
